// ----- design/atrlr_pkg.sv -----
// Package for the modem response line reader: codes, characters and reset values.
`default_nettype none
package atrlr_pkg;

    // Geometry and register reset values
    localparam int LINE_BYTES_DEF    = 128;
    localparam int LF_WAIT_W         = 16;
    localparam int RESP_TIMER_W      = 32;
    localparam int CFG_DATA_W        = 32;
    localparam int CFG_INDEX_W       = 1;
    localparam int LEN_W             = 7;
    localparam int IDX_W             = 7;
    localparam int BYTE_W            = 8;
    localparam logic [LF_WAIT_W-1:0]    LF_WAIT_RST      = 16'd50;
    localparam logic [RESP_TIMER_W-1:0] RESP_TIMEOUT_RST = 32'd1000;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LF_WAIT      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESP_TIMEOUT = 1'd1;

    // Line characters
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_START = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_LINE    = 3'd0,
        KIND_OK      = 3'd1,
        KIND_ERROR   = 3'd2,
        KIND_TIMEOUT = 3'd3,
        KIND_READ    = 3'd4
    } t_kind;

    // Character of "OK" at a position below 2
    function automatic logic [BYTE_W-1:0] ok_char(input logic pos);
        return pos ? 8'h4B : 8'h4F;
    endfunction

    // Character of "ERROR" at a position below 5
    function automatic logic [BYTE_W-1:0] err_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h45;
            3'd1:    ch = 8'h52;
            3'd2:    ch = 8'h52;
            3'd3:    ch = 8'h4F;
            default: ch = 8'h52;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// ----- design/atrlr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module atrlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 127
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- design/at_response_line_reader.sv -----
// Top level of the modem response line reader.
//
// Takes one request per cycle (received byte, timer tick, start of a wait, or
// read of a stored line byte) while the result channel does not stall, and returns
// at most one result through the result stage and the output register. Line bytes
// are kept in a single RAM with a registered read; a read request always sees
// every byte written by earlier requests, since one request touches the RAM per
// cycle. Classification (OK, ERROR, other line, timeout) is done incrementally
// as bytes arrive, so no further work is needed at the line end. Results pass
// through an output register, so a stalled consumer holds back input only once
// both the result stage and the output register are full. Configuration writes
// take effect on the next edge and are meant for idle periods only.
`default_nettype none
module at_response_line_reader #(
    parameter int LINE_BYTES = atrlr_pkg::LINE_BYTES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration port
    input  wire logic                                i_cfg_we,
    input  wire logic [atrlr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [atrlr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Request channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [1:0]                          i_op,
    input  wire logic [atrlr_pkg::BYTE_W-1:0]        i_rx_byte,
    input  wire logic [atrlr_pkg::IDX_W-1:0]         i_read_index,
    // Result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [2:0]                               o_kind,
    output logic [atrlr_pkg::LEN_W-1:0]              o_line_length,
    output logic [atrlr_pkg::BYTE_W-1:0]             o_read_data
);

    localparam int CAP  = LINE_BYTES - 1;
    localparam int CW   = $clog2(LINE_BYTES);
    localparam int AW   = $clog2(CAP);
    localparam int CMPW = (CW > atrlr_pkg::IDX_W) ? CW : atrlr_pkg::IDX_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAP);
    localparam logic [CMPW-1:0] OK_LEN = CMPW'(2);
    localparam logic [CMPW-1:0] ERR_LEN = CMPW'(5);

    // Configuration registers
    logic [atrlr_pkg::LF_WAIT_W-1:0]    r_lf_wait;
    logic [atrlr_pkg::RESP_TIMER_W-1:0] r_resp_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lf_wait      <= atrlr_pkg::LF_WAIT_RST;
            r_resp_timeout <= atrlr_pkg::RESP_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                atrlr_pkg::REG_LF_WAIT:
                    r_lf_wait <= i_cfg_wdata[atrlr_pkg::LF_WAIT_W-1:0];
                atrlr_pkg::REG_RESP_TIMEOUT:
                    r_resp_timeout <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Line state
    logic [CW-1:0]                      r_count,   n_count;
    logic                               r_cr,      n_cr;
    logic [atrlr_pkg::LF_WAIT_W-1:0]    r_lf,      n_lf;
    logic [atrlr_pkg::RESP_TIMER_W-1:0] r_resp,    n_resp;
    logic                               r_waiting, n_waiting;
    logic                               r_ok,      n_ok;
    logic                               r_err,     n_err;
    logic                               r_done,    n_done;

    // Result stage (cycle of the RAM read) and output register
    logic                          r_s1_valid;
    atrlr_pkg::t_kind              r_s1_kind;
    logic [atrlr_pkg::LEN_W-1:0]   r_s1_len;
    logic                          r_s1_hit;
    logic                          r_out_valid;
    atrlr_pkg::t_kind              r_out_kind;
    logic [atrlr_pkg::LEN_W-1:0]   r_out_len;
    logic [atrlr_pkg::BYTE_W-1:0]  r_out_data;

    logic                          accept;
    logic                          s1_move;
    atrlr_pkg::t_op                op;
    logic                          res_valid;
    atrlr_pkg::t_kind              res_kind;
    logic                          res_hit;
    logic [CMPW-1:0]               count_x;
    logic [CMPW-1:0]               idx_x;
    logic [CMPW-1:0]               pos_x;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic                          rd_en;
    logic [atrlr_pkg::BYTE_W-1:0]  ram_rdata;

    assign op       = atrlr_pkg::t_op'(i_op);
    assign s1_move  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign accept   = i_in_valid && o_in_ready;
    assign count_x  = CMPW'(r_count);
    assign idx_x    = CMPW'(i_read_index);
    assign rd_en    = accept && (op == atrlr_pkg::OP_READ);

    // Next state of the line logic for the accepted request
    always_comb begin
        n_count   = r_count;
        n_cr      = r_cr;
        n_lf      = r_lf;
        n_resp    = r_resp;
        n_waiting = r_waiting;
        n_ok      = r_ok;
        n_err     = r_err;
        n_done    = r_done;
        res_valid = 1'b0;
        res_kind  = atrlr_pkg::KIND_LINE;
        res_hit   = 1'b0;
        wr_en     = 1'b0;
        pos_x     = CMPW'(r_count);
        if (accept) begin
            unique case (op)
                atrlr_pkg::OP_BYTE: begin
                    if (r_waiting) begin
                        // Line end: LF, or any byte after a CR
                        if (i_rx_byte == atrlr_pkg::CHAR_LF || r_cr) begin
                            n_cr = 1'b0;
                            n_lf = '0;
                            if (!r_done && r_count != '0) begin
                                n_done    = 1'b1;
                                res_valid = 1'b1;
                                if (r_ok && count_x == OK_LEN) begin
                                    n_waiting = 1'b0;
                                    res_kind  = atrlr_pkg::KIND_OK;
                                end else if (r_err && count_x == ERR_LEN) begin
                                    n_waiting = 1'b0;
                                    res_kind  = atrlr_pkg::KIND_ERROR;
                                end
                            end
                        end
                        // Byte handling once no CR is pending
                        if (i_rx_byte != atrlr_pkg::CHAR_LF && n_waiting) begin
                            if (i_rx_byte == atrlr_pkg::CHAR_CR) begin
                                n_cr = 1'b1;
                                n_lf = '0;
                            end else begin
                                if (n_done) begin
                                    n_done  = 1'b0;
                                    n_count = '0;
                                    n_ok    = 1'b1;
                                    n_err   = 1'b1;
                                end
                                pos_x = CMPW'(n_count);
                                if (n_count < CAP_C) begin
                                    n_ok  = n_ok && (pos_x < CMPW'(2))
                                            && (atrlr_pkg::ok_char(pos_x[0]) == i_rx_byte);
                                    n_err = n_err && (pos_x < CMPW'(5))
                                            && (atrlr_pkg::err_char(pos_x[2:0]) == i_rx_byte);
                                    wr_en   = 1'b1;
                                    n_count = n_count + 1'b1;
                                end
                            end
                        end
                    end
                end
                atrlr_pkg::OP_TICK: begin
                    if (r_waiting) begin
                        if (r_resp != '1) begin
                            n_resp = r_resp + 1'b1;
                        end
                        if (n_resp >= r_resp_timeout) begin
                            // Response timeout wins over the CR wait
                            n_waiting = 1'b0;
                            n_cr      = 1'b0;
                            n_lf      = '0;
                            n_done    = 1'b1;
                            res_valid = 1'b1;
                            res_kind  = atrlr_pkg::KIND_TIMEOUT;
                        end else if (r_cr) begin
                            if (r_lf != '1) begin
                                n_lf = r_lf + 1'b1;
                            end
                            if (n_lf >= r_lf_wait) begin
                                // Lone CR ends the line
                                n_cr = 1'b0;
                                n_lf = '0;
                                if (!r_done && r_count != '0) begin
                                    n_done    = 1'b1;
                                    res_valid = 1'b1;
                                    if (r_ok && count_x == OK_LEN) begin
                                        n_waiting = 1'b0;
                                        res_kind  = atrlr_pkg::KIND_OK;
                                    end else if (r_err && count_x == ERR_LEN) begin
                                        n_waiting = 1'b0;
                                        res_kind  = atrlr_pkg::KIND_ERROR;
                                    end
                                end
                            end
                        end
                    end
                end
                atrlr_pkg::OP_START: begin
                    n_waiting = 1'b1;
                    n_resp    = '0;
                    n_cr      = 1'b0;
                    n_lf      = '0;
                    n_done    = 1'b1;
                end
                atrlr_pkg::OP_READ: begin
                    res_valid = 1'b1;
                    res_kind  = atrlr_pkg::KIND_READ;
                    res_hit   = idx_x < count_x;
                end
                default: ;
            endcase
        end
    end

    assign wr_addr = pos_x[AW-1:0];

    // Line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cr      <= 1'b0;
            r_lf      <= '0;
            r_resp    <= '0;
            r_waiting <= 1'b0;
            r_ok      <= 1'b1;
            r_err     <= 1'b1;
            r_done    <= 1'b1;
        end else begin
            r_count   <= n_count;
            r_cr      <= n_cr;
            r_lf      <= n_lf;
            r_resp    <= n_resp;
            r_waiting <= n_waiting;
            r_ok      <= n_ok;
            r_err     <= n_err;
            r_done    <= n_done;
        end
    end

    // Line store
    atrlr_ram #(
        .WIDTH (atrlr_pkg::BYTE_W),
        .DEPTH (CAP)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_rx_byte),
        .i_re    (rd_en),
        .i_raddr (idx_x[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Result stage: waits for the RAM read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= res_valid;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind <= res_kind;
            r_s1_hit  <= res_hit;
            r_s1_len  <= (res_kind == atrlr_pkg::KIND_TIMEOUT) ? '0 : count_x[atrlr_pkg::LEN_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_kind <= r_s1_kind;
            r_out_len  <= r_s1_len;
            r_out_data <= (r_s1_kind == atrlr_pkg::KIND_READ && r_s1_hit) ? ram_rdata : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_line_length = r_out_len;
    assign o_read_data   = r_out_data;

endmodule
`default_nettype wire

// ----- verif/at_response_line_reader_tb.sv -----
// Testbench for at_response_line_reader: directed and random requests checked by a line model.
`timescale 1ns / 1ps
module at_response_line_reader_tb;
    import atrlr_pkg::*;

    localparam int STORE_DEPTH     = LINE_BYTES_DEF - 1;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 16;
    localparam int PRESSURE_CYCLES = 200;
    localparam logic [15:0] OK_WORD    = 16'h4F4B;
    localparam logic [39:0] ERROR_WORD = 40'h4552524F52;

    typedef struct packed {
        t_kind               kind;
        logic [LEN_W-1:0]    len;
        logic [BYTE_W-1:0]   data;
    } reply_t;

    typedef struct {
        t_op                 op;
        logic [BYTE_W-1:0]   rx;
        logic [IDX_W-1:0]    idx;
        bit                  typed;
        reply_t              want;
    } plan_row_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_INDEX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [1:0]              i_op;
    logic [BYTE_W-1:0]       i_rx_byte;
    logic [IDX_W-1:0]        i_read_index;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [2:0]              o_kind;
    logic [LEN_W-1:0]        o_line_length;
    logic [BYTE_W-1:0]       o_read_data;

    // Typed expectation travelling with the request (directed rows only)
    bit                      req_typed;
    reply_t                  req_typed_reply;

    reply_t                  expected_replies [$];
    plan_row_t               directed_plan [$];
    int                      mismatch_count = 0;
    int                      items_sent = 0;
    int                      idle_cycles = 0;
    bit                      burst_mode = 1'b0;
    bit                      pressure_req = 1'b0;
    logic [15:0]             phase_lf = LF_WAIT_RST;
    logic [31:0]             phase_timeout = RESP_TIMEOUT_RST;

    // Line model state
    logic [BYTE_W-1:0]       line_buf [STORE_DEPTH];
    int                      line_fill = 0;
    bit                      cr_held = 1'b0;
    logic [15:0]             lf_ticks = '0;
    logic [31:0]             resp_ticks = '0;
    bit                      awaiting = 1'b0;
    bit                      ok_track = 1'b1;
    bit                      err_track = 1'b1;
    bit                      line_closed = 1'b1;
    logic [15:0]             cfg_lf_wait = LF_WAIT_RST;
    logic [31:0]             cfg_timeout = RESP_TIMEOUT_RST;

    at_response_line_reader dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_rx_byte     (i_rx_byte),
        .i_read_index  (i_read_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_line_length (o_line_length),
        .o_read_data   (o_read_data)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Line model
    // ---------------------------------------------------------------

    // End of the current line; reports it unless empty or already closed
    task automatic close_line(output bit got, output reply_t r);
        got = 1'b0;
        r = '0;
        cr_held = 1'b0;
        lf_ticks = '0;
        if (!line_closed && line_fill != 0) begin
            line_closed = 1'b1;
            got = 1'b1;
            r.len = LEN_W'(line_fill);
            if (ok_track && line_fill == 2) begin
                awaiting = 1'b0;
                r.kind = KIND_OK;
            end else if (err_track && line_fill == 5) begin
                awaiting = 1'b0;
                r.kind = KIND_ERROR;
            end else begin
                r.kind = KIND_LINE;
            end
        end
    endtask

    // Byte handling with no CR outstanding
    task automatic store_char(input logic [7:0] c, output bit got, output reply_t r);
        got = 1'b0;
        r = '0;
        if (c == CHAR_CR) begin
            cr_held = 1'b1;
            lf_ticks = '0;
        end else if (c == CHAR_LF) begin
            close_line(got, r);
        end else begin
            if (line_closed) begin
                line_closed = 1'b0;
                line_fill = 0;
                ok_track = 1'b1;
                err_track = 1'b1;
            end
            // bytes past the store capacity are dropped and leave matching alone
            if (line_fill < STORE_DEPTH) begin
                if (line_fill >= 2 || OK_WORD[15 - 8*line_fill -: 8] != c)
                    ok_track = 1'b0;
                if (line_fill >= 5 || ERROR_WORD[39 - 8*line_fill -: 8] != c)
                    err_track = 1'b0;
                line_buf[line_fill] = c;
                line_fill++;
            end
        end
    endtask

    // Expected result of one accepted request
    task automatic predict_reply(input t_op op, input logic [7:0] c,
                                 input logic [6:0] idx, output bit got, output reply_t r);
        bit     spare_got;
        reply_t spare;
        got = 1'b0;
        r = '0;
        case (op)
            OP_BYTE: begin
                if (awaiting) begin
                    if (!cr_held) begin
                        store_char(c, got, r);
                    end else if (c == CHAR_LF) begin
                        close_line(got, r);
                    end else begin
                        // lone CR ends the line; the byte opens the next one
                        close_line(got, r);
                        if (awaiting)
                            store_char(c, spare_got, spare);
                    end
                end
            end
            OP_TICK: begin
                if (awaiting) begin
                    if (resp_ticks != '1)
                        resp_ticks++;
                    // timeout takes priority over the LF wait
                    if (resp_ticks >= cfg_timeout) begin
                        awaiting = 1'b0;
                        cr_held = 1'b0;
                        lf_ticks = '0;
                        line_closed = 1'b1;
                        got = 1'b1;
                        r.kind = KIND_TIMEOUT;
                    end else if (cr_held) begin
                        if (lf_ticks != '1)
                            lf_ticks++;
                        if (lf_ticks >= cfg_lf_wait)
                            close_line(got, r);
                    end
                end
            end
            OP_START: begin
                awaiting = 1'b1;
                resp_ticks = '0;
                cr_held = 1'b0;
                lf_ticks = '0;
                line_closed = 1'b1;
            end
            default: begin
                got = 1'b1;
                r.kind = KIND_READ;
                r.len = LEN_W'(line_fill);
                r.data = (idx < line_fill) ? line_buf[idx] : 8'h00;
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Monitor: checks results, tracks config, predicts each request
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        reply_t want;
        reply_t guess;
        bit     got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    $error("result with no request outstanding: kind %0d", o_kind);
                    mismatch_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (o_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, o_kind);
                        mismatch_count++;
                    end
                    if (o_line_length !== want.len) begin
                        $error("line_length: expected %0d, got %0d", want.len, o_line_length);
                        mismatch_count++;
                    end
                    if (o_read_data !== want.data) begin
                        $error("read_data: expected 0x%02h, got 0x%02h", want.data, o_read_data);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LF_WAIT:      cfg_lf_wait = i_cfg_wdata[15:0];
                    REG_RESP_TIMEOUT: cfg_timeout = i_cfg_wdata;
                    default:          ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                predict_reply(t_op'(i_op), i_rx_byte, i_read_index, got, guess);
                if (req_typed)
                    expected_replies.push_back(req_typed_reply);
                else if (got)
                    expected_replies.push_back(guess);
            end
        end
    end

    // Watchdog: consecutive cycles with no handshake and no config write
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Mostly short gaps, a few long ones, none in burst mode
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Read positions lean toward the short lines that are usually held
    function automatic logic [6:0] rand_index();
        if ($urandom_range(0, 99) < 70)
            return 7'($urandom_range(0, 8));
        return 7'($urandom_range(0, STORE_DEPTH - 1));
    endfunction

    function automatic plan_row_t plan_row(input t_op op, input logic [7:0] rx,
                                           input logic [6:0] idx, input bit typed,
                                           input t_kind kind, input logic [6:0] len,
                                           input logic [7:0] data);
        plan_row_t row;
        row.op = op;
        row.rx = rx;
        row.idx = idx;
        row.typed = typed;
        row.want.kind = kind;
        row.want.len = len;
        row.want.data = data;
        return row;
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_request(input t_op op, input logic [7:0] rx, input logic [6:0] idx,
                                input bit typed, input reply_t want, input bit counted);
        int gap;
        gap = pick_idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_rx_byte <= rx;
        i_read_index <= idx;
        req_typed <= typed;
        req_typed_reply <= want;
        do @(posedge i_clk); while (!o_in_ready);
        if (counted)
            items_sent++;
    endtask

    task automatic issue(input t_op op);
        send_request(op, 8'($urandom_range(0, 255)), rand_index(), 1'b0, '0, 1'b1);
    endtask

    // A line byte, sometimes preceded by a tick or a read
    task automatic send_char(input logic [7:0] c);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            issue(OP_TICK);
        else if (r < 12)
            issue(OP_READ);
        send_request(OP_BYTE, c, rand_index(), 1'b0, '0, 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // LF, CR LF, a lone CR closed by the next byte, or CR followed by ticks
    task automatic end_line();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            send_char(CHAR_LF);
        end else begin
            send_char(CHAR_CR);
            if (r < 70) begin
                send_char(CHAR_LF);
            end else if (r >= 85) begin
                n = (phase_lf <= 8) ? $urandom_range(0, phase_lf + 1) : $urandom_range(0, 3);
                repeat (n) issue(OP_TICK);
            end
        end
    endtask

    task automatic random_body();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            repeat ($urandom_range(0, 8)) send_char(8'($urandom_range(32, 126)));
        end else if (r < 50) begin
            repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
        end else if (r < 65) begin
            // lines that nearly match a final reply
            case ($urandom_range(0, 5))
                0:       send_text("O");
                1:       send_text("OKK");
                2:       send_text("ERRO");
                3:       send_text("ERRORR");
                4:       send_text("ok");
                default: send_text("ERROK");
            endcase
        end else if (r < 68) begin
            // overlong line, cut at the store capacity
            if ($urandom_range(0, 1))
                send_text("OK");
            repeat ($urandom_range(124, 132)) send_char(8'($urandom_range(32, 126)));
        end
    endtask

    // One wait: start, a few lines, then a final reply, a timeout or an open line
    task automatic run_session();
        int r;
        issue(OP_START);
        repeat ($urandom_range(0, 4)) begin
            random_body();
            end_line();
        end
        r = $urandom_range(0, 99);
        if (r < 40) begin
            send_text("OK");
            end_line();
        end else if (r < 75) begin
            send_text("ERROR");
            end_line();
        end else if (r < 90 && phase_timeout <= 64) begin
            repeat (phase_timeout + 1) issue(OP_TICK);
        end else begin
            random_body();
        end
        repeat ($urandom_range(0, 2)) issue(OP_READ);
        // trailing bytes and ticks, mostly ignored by an idle block
        repeat ($urandom_range(0, 2))
            send_request($urandom_range(0, 1) ? OP_BYTE : OP_TICK,
                         8'($urandom_range(0, 255)), rand_index(), 1'b0, '0, 1'b0);
    endtask

    task automatic run_random(input int target);
        int first;
        first = items_sent;
        while (items_sent - first < target)
            run_session();
    endtask

    // Register writes only once every result is out and the pipeline is empty
    task automatic configure(input logic [15:0] lf, input logic [31:0] limit);
        i_in_valid <= 1'b0;
        // let the monitor log the last accepted request first
        @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_LF_WAIT;
        i_cfg_wdata <= {16'($urandom), lf};
        @(posedge i_clk);
        i_cfg_index <= REG_RESP_TIMEOUT;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        phase_lf = lf;
        phase_timeout = limit;
    endtask

    // ---------------------------------------------------------------
    // Result sink: random stalls, one long hold-off on request
    // ---------------------------------------------------------------
    initial begin : result_sink
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (pressure_req) begin
                i_out_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge i_clk);
                pressure_req = 1'b0;
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                stall = pick_idle_len();
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= REG_LF_WAIT;
        i_cfg_wdata <= '0;
        i_in_valid <= 1'b0;
        i_op <= OP_BYTE;
        i_rx_byte <= '0;
        i_read_index <= '0;
        req_typed <= 1'b0;
        req_typed_reply <= '0;

        // Directed: reset read, idle drop, lone CR, empty line, OK, ERROR, reads
        directed_plan.push_back(plan_row(OP_READ,  8'h00, 7'd0,   1, KIND_READ,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  8'h5A, 7'd0,   0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_TICK,  8'hFF, 7'd126, 0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_START, 8'h00, 7'd0,   0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  8'h00, 7'd0,   0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  8'hFF, 7'd126, 0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  CHAR_CR, 7'd0, 0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  8'h4F, 7'd0,   1, KIND_LINE,  7'd2, 8'h00));
        directed_plan.push_back(plan_row(OP_READ,  8'hFF, 7'd126, 1, KIND_READ,  7'd1, 8'h00));
        directed_plan.push_back(plan_row(OP_READ,  8'h00, 7'd0,   1, KIND_READ,  7'd1, 8'h4F));
        directed_plan.push_back(plan_row(OP_BYTE,  CHAR_LF, 7'd0, 1, KIND_LINE,  7'd1, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  CHAR_LF, 7'd0, 0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  8'h4F, 7'd0,   0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  8'h4B, 7'd0,   0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  CHAR_CR, 7'd0, 0, KIND_LINE,  7'd0, 8'h00));
        // byte after the lone CR that ends the wait is dropped
        directed_plan.push_back(plan_row(OP_BYTE,  8'h45, 7'd0,   1, KIND_OK,    7'd2, 8'h00));
        directed_plan.push_back(plan_row(OP_START, 8'hFF, 7'd126, 0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  8'h45, 7'd0,   0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  8'h52, 7'd0,   0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  8'h52, 7'd0,   0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  8'h4F, 7'd0,   0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  8'h52, 7'd0,   0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_BYTE,  CHAR_LF, 7'd0, 1, KIND_ERROR, 7'd5, 8'h00));
        directed_plan.push_back(plan_row(OP_TICK,  8'h00, 7'd0,   0, KIND_LINE,  7'd0, 8'h00));
        directed_plan.push_back(plan_row(OP_READ,  8'hFF, 7'd4,   1, KIND_READ,  7'd5, 8'h52));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[k])
            send_request(directed_plan[k].op, directed_plan[k].rx, directed_plan[k].idx,
                         directed_plan[k].typed, directed_plan[k].want, 1'b1);

        // Reset settings, then the smallest limits
        run_random(100);
        configure(16'd1, 32'd1);
        run_random(30);

        // Largest limits; results back up while the sink holds off
        configure(16'hFFFF, 32'hFFFF_FFFF);
        pressure_req = 1'b1;
        burst_mode = 1'b1;
        repeat (24) issue(OP_READ);
        burst_mode = 1'b0;
        run_random(120);

        // Short limits so LF waits and timeouts fire often
        configure(16'd2, 32'd40);
        run_random(150);
        configure(16'd3, 32'd12);
        burst_mode = 1'b1;
        run_random(60);
        burst_mode = 1'b0;
        run_random(60);
        configure(16'($urandom_range(1, 8)), 32'($urandom_range(10, 60)));
        run_random(120);

        // Drain
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
